// File: hw/rtl/pdsc_pkg.sv
package pdsc_pkg;

   // Defaults for the top-level parameters
   localparam int MESSAGE_BYTES_DEF = 48;
   localparam int MAX_OBJECTS_DEF   = 10;

   // Result queue depth; the pointers wrap naturally, so keep it a power of two
   localparam int QUEUE_DEPTH = 8;

   // Configuration register indexes
   localparam int          CSR_INDEX_W  = 1;
   localparam int          CSR_DATA_W   = 15;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FLOOR    = 1'd1;

   // Register and per-message reset values
   localparam logic [7:0]  SETPOINT_RESET = 8'd100;
   localparam logic [14:0] FLOOR_RESET    = 15'd4000;
   localparam logic [14:0] PPS_LOW_RESET  = 15'd20000;

   // Supply kinds
   localparam logic [2:0] KIND_NONE     = 3'd0;
   localparam logic [2:0] KIND_FIXED    = 3'd1;
   localparam logic [2:0] KIND_PROG     = 3'd2;
   localparam logic [2:0] KIND_ADJ      = 3'd3;
   localparam logic [2:0] KIND_RESERVED = 3'd4;

   // Standard fixed voltages
   localparam logic [15:0] V5_MV  = 16'd5000;
   localparam logic [15:0] V9_MV  = 16'd9000;
   localparam logic [15:0] V12_MV = 16'd12000;
   localparam logic [15:0] V15_MV = 16'd15000;
   localparam logic [15:0] V20_MV = 16'd20000;

   // Field scales
   localparam logic [15:0] FIXED_MV_STEP = 16'd50;
   localparam logic [15:0] FIXED_MA_STEP = 16'd10;
   localparam logic [15:0] AUG_MV_STEP   = 16'd100;
   localparam logic [12:0] PROG_MA_STEP  = 13'd50;

   // x / 100 for 15-bit x as (x * 5243) >> 19
   localparam logic [12:0] DIV100_MUL   = 13'd5243;
   localparam int          DIV100_SHIFT = 19;

   // One result beat
   typedef struct packed {
      logic [3:0]  entry_index;
      logic [2:0]  supply_kind;
      logic [15:0] min_mv;
      logic [15:0] max_mv;
      logic [12:0] limit_value;
      logic [5:0]  voltage_mask;
      logic [14:0] pps_min_mv;
      logic [14:0] pps_max_mv;
      logic [7:0]  pps_setpoint;
      logic        is_summary;
   } pdsc_item_type;

   // Parser output: one decoded object and the raw summary state
   typedef struct packed {
      logic        obj_valid;
      logic        sum_valid;
      logic [3:0]  entry_index;
      logic [2:0]  supply_kind;
      logic [15:0] min_mv;
      logic [15:0] max_mv;
      logic [12:0] limit_value;
      logic [3:0]  count;
      logic [5:0]  mask;
      logic [14:0] pps_low;
      logic [14:0] pps_high;
   } pdsc_rec_type;

   // Up to two result beats written into the queue in one cycle
   typedef struct packed {
      logic          valid_a;
      logic          valid_b;
      pdsc_item_type item_a;
      pdsc_item_type item_b;
   } pdsc_push_type;

endpackage

// File: hw/rtl/pdsc_parser.sv
module pdsc_parser #(
   parameter int MESSAGE_BYTES = pdsc_pkg::MESSAGE_BYTES_DEF,
   parameter int MAX_OBJECTS   = pdsc_pkg::MAX_OBJECTS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   first_byte,
   input  logic                   final_byte,
   output pdsc_pkg::pdsc_rec_type rec
);

   localparam int PW = $clog2(MESSAGE_BYTES + 1);
   localparam int IW = PW - 2;
   localparam logic [PW-1:0] POS_END = PW'(MESSAGE_BYTES);
   localparam logic [6:0]    LIM_MAX = 7'(MAX_OBJECTS);

   // Message state
   logic [PW-1:0] pos_ff,   pos_in;
   logic [15:0]   hdr_ff,   hdr_in;
   logic [15:0]   ehdr_ff,  ehdr_in;
   logic [23:0]   asm_ff,   asm_in;
   logic [3:0]    count_ff, count_in;
   logic [5:0]    mask_ff,  mask_in;
   logic [14:0]   low_ff,   low_in;
   logic [14:0]   high_ff,  high_in;

   // Output record
   logic                   obj_v_ff, obj_v_in;
   logic                   sum_v_ff, sum_v_in;
   pdsc_pkg::pdsc_rec_type rec_ff,   rec_in;

   always_comb begin
      logic [PW-1:0] pos_c;
      logic [15:0]   hdr_c;
      logic [15:0]   ehdr_c;
      logic          ext;
      logic [PW-1:0] off;
      logic [IW-1:0] idx;
      logic [1:0]    sub;
      logic [6:0]    lim;
      logic [31:0]   w;
      logic          aug;
      logic          adj;
      logic [15:0]   mn;
      logic [15:0]   mx;
      logic [12:0]   lv;
      logic [2:0]    kind;
      logic          obj_hit;

      // Start of message clears the per-message state
      pos_c    = first_byte ? '0 : pos_ff;
      hdr_c    = first_byte ? '0 : hdr_ff;
      ehdr_c   = first_byte ? '0 : ehdr_ff;
      asm_in   = first_byte ? '0 : asm_ff;
      count_in = first_byte ? '0 : count_ff;
      mask_in  = first_byte ? '0 : mask_ff;
      low_in   = first_byte ? pdsc_pkg::PPS_LOW_RESET : low_ff;
      high_in  = first_byte ? '0 : high_ff;
      pos_in   = pos_c;
      hdr_in   = hdr_c;
      ehdr_in  = ehdr_c;

      ext     = hdr_c[15];
      off     = pos_c - (ext ? PW'(4) : PW'(2));
      idx     = off[PW-1:2];
      sub     = off[1:0];
      lim     = ext ? ((ehdr_c[8:2] > LIM_MAX) ? LIM_MAX : ehdr_c[8:2])
                    : {4'd0, hdr_c[14:12]};
      w       = {data_byte, asm_in};
      obj_hit = 1'b0;

      // Decode the completed object word
      aug = (w[31:30] == 2'b11);
      adj = aug && ext && (w[29:28] == 2'b01);
      if (aug) begin
         mn   = 16'(w[15:8]) * pdsc_pkg::AUG_MV_STEP;
         mx   = adj ? 16'(w[25:17]) * pdsc_pkg::AUG_MV_STEP
                    : 16'(w[24:17]) * pdsc_pkg::AUG_MV_STEP;
         lv   = adj ? 13'(w[7:0]) : 13'(w[6:0]) * pdsc_pkg::PROG_MA_STEP;
         kind = adj ? pdsc_pkg::KIND_ADJ : pdsc_pkg::KIND_PROG;
      end else begin
         mn   = 16'(w[19:10]) * pdsc_pkg::FIXED_MV_STEP;
         mx   = 16'(w[9:0]) * pdsc_pkg::FIXED_MA_STEP;
         lv   = '0;
         kind = (ext && w[19:0] == 20'd0) ? pdsc_pkg::KIND_RESERVED
                                          : pdsc_pkg::KIND_FIXED;
      end

      // Advance the byte position and route the byte
      if (pos_c < POS_END) begin
         pos_in = pos_c + PW'(1);
         if (pos_c < PW'(2)) begin
            if (pos_c[0]) hdr_in[15:8] = hdr_c[15:8] | data_byte;
            else          hdr_in[7:0]  = hdr_c[7:0]  | data_byte;
         end else if (ext && pos_c < PW'(4)) begin
            if (pos_c[0]) ehdr_in[15:8] = ehdr_c[15:8] | data_byte;
            else          ehdr_in[7:0]  = ehdr_c[7:0]  | data_byte;
         end else if (7'(idx) < lim) begin
            case (sub)
               2'd0: asm_in = {16'd0, data_byte};
               2'd1: asm_in[15:8]  = asm_in[15:8]  | data_byte;
               2'd2: asm_in[23:16] = asm_in[23:16] | data_byte;
               default: begin
                  obj_hit  = 1'b1;
                  count_in = 4'(idx) + 4'd1;
               end
            endcase
         end
      end

      // Fold the object into the summary
      if (obj_hit) begin
         if (kind == pdsc_pkg::KIND_PROG) begin
            mask_in[5] = 1'b1;
            if (mn < 16'(low_in))  low_in  = mn[14:0];
            if (mx > 16'(high_in)) high_in = mx[14:0];
         end else if (kind == pdsc_pkg::KIND_FIXED) begin
            if (mn == pdsc_pkg::V5_MV)  mask_in[0] = 1'b1;
            if (mn == pdsc_pkg::V9_MV)  mask_in[1] = 1'b1;
            if (mn == pdsc_pkg::V12_MV) mask_in[2] = 1'b1;
            if (mn == pdsc_pkg::V15_MV) mask_in[3] = 1'b1;
            if (mn == pdsc_pkg::V20_MV) mask_in[4] = 1'b1;
         end
      end

      obj_v_in           = accept && obj_hit;
      sum_v_in           = accept && final_byte;
      rec_in             = rec_ff;
      rec_in.obj_valid   = 1'b0;
      rec_in.sum_valid   = 1'b0;
      rec_in.entry_index = 4'(idx);
      rec_in.supply_kind = kind;
      rec_in.min_mv      = mn;
      rec_in.max_mv      = mx;
      rec_in.limit_value = lv;
      rec_in.count       = count_in;
      rec_in.mask        = mask_in;
      rec_in.pps_low     = low_in;
      rec_in.pps_high    = high_in;
   end

   // Hold state between beats; take the new values on accept
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         hdr_ff   <= '0;
         ehdr_ff  <= '0;
         asm_ff   <= '0;
         count_ff <= '0;
         mask_ff  <= '0;
         low_ff   <= pdsc_pkg::PPS_LOW_RESET;
         high_ff  <= '0;
         obj_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
      end else begin
         obj_v_ff <= obj_v_in;
         sum_v_ff <= sum_v_in;
         if (accept) begin
            pos_ff   <= pos_in;
            hdr_ff   <= hdr_in;
            ehdr_ff  <= ehdr_in;
            asm_ff   <= asm_in;
            count_ff <= count_in;
            mask_ff  <= mask_in;
            low_ff   <= low_in;
            high_ff  <= high_in;
         end
      end
   end

   // Record payload
   always_ff @(posedge clock) begin
      if (accept) rec_ff <= rec_in;
   end

   always_comb begin
      rec           = rec_ff;
      rec.obj_valid = obj_v_ff;
      rec.sum_valid = sum_v_ff;
   end

endmodule

// File: hw/rtl/pdsc_summary.sv
module pdsc_summary (
   input  logic                    clock,
   input  logic                    reset,
   input  pdsc_pkg::pdsc_rec_type  rec,
   input  logic [7:0]              setpoint,
   input  logic [14:0]             floor_mv,
   output pdsc_pkg::pdsc_push_type push,
   output logic [1:0]              load
);

   // Stage two: clamp, compare and divide
   logic          obj_v_ff, obj_v_in;
   logic          sum_v_ff, sum_v_in;
   pdsc_pkg::pdsc_item_type obj_ff, obj_in;
   logic [3:0]    count_ff;
   logic [5:0]    mask_ff;
   logic [14:0]   pmin_ff,  pmin_in;
   logic [14:0]   pmax_ff;
   logic          lt_ff,    lt_in;
   logic [8:0]    pmin_q_ff, pmin_q_in;
   logic [8:0]    pmax_q_ff, pmax_q_in;
   logic [7:0]    sp_ff;

   logic [27:0]   pmin_prod;
   logic [27:0]   pmax_prod;

   always_comb begin
      obj_v_in = rec.obj_valid;
      sum_v_in = rec.sum_valid;

      obj_in              = '0;
      obj_in.entry_index  = rec.entry_index;
      obj_in.supply_kind  = rec.supply_kind;
      obj_in.min_mv       = rec.min_mv;
      obj_in.max_mv       = rec.max_mv;
      obj_in.limit_value  = rec.limit_value;

      // Raise the lowest minimum to the floor
      pmin_in   = (rec.pps_low < floor_mv) ? floor_mv : rec.pps_low;
      lt_in     = (15'(setpoint) * 15'd100) < pmin_in;
      pmin_prod = 28'(pmin_in) * 28'(pdsc_pkg::DIV100_MUL);
      pmax_prod = 28'(rec.pps_high) * 28'(pdsc_pkg::DIV100_MUL);
      pmin_q_in = 9'(pmin_prod >> pdsc_pkg::DIV100_SHIFT);
      pmax_q_in = 9'(pmax_prod >> pdsc_pkg::DIV100_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_v_ff <= 1'b0;
         sum_v_ff <= 1'b0;
      end else begin
         obj_v_ff <= obj_v_in;
         sum_v_ff <= sum_v_in;
      end
   end

   always_ff @(posedge clock) begin
      obj_ff    <= obj_in;
      count_ff  <= rec.count;
      mask_ff   <= rec.mask;
      pmin_ff   <= pmin_in;
      pmax_ff   <= rec.pps_high;
      lt_ff     <= lt_in;
      pmin_q_ff <= pmin_q_in;
      pmax_q_ff <= pmax_q_in;
      sp_ff     <= setpoint;
   end

   // Stage three: raise then lower the setpoint and build the beats
   always_comb begin
      logic [8:0]  sp_up;
      logic        gt;
      logic [8:0]  sp_fin;
      pdsc_pkg::pdsc_item_type sum_item;

      sp_up  = lt_ff ? pmin_q_ff : {1'b0, sp_ff};
      gt     = (16'(sp_up) * 16'd100) > 16'(pmax_ff);
      sp_fin = gt ? pmax_q_ff : sp_up;

      sum_item              = '0;
      sum_item.entry_index  = count_ff;
      sum_item.supply_kind  = pdsc_pkg::KIND_NONE;
      sum_item.voltage_mask = mask_ff;
      sum_item.pps_min_mv   = pmin_ff;
      sum_item.pps_max_mv   = pmax_ff;
      sum_item.pps_setpoint = sp_fin[7:0];
      sum_item.is_summary   = 1'b1;

      push.valid_a = obj_v_ff || sum_v_ff;
      push.valid_b = obj_v_ff && sum_v_ff;
      push.item_a  = obj_v_ff ? obj_ff : sum_item;
      push.item_b  = sum_item;
   end

   assign load = 2'(obj_v_ff) + 2'(sum_v_ff);

endmodule

// File: hw/rtl/pdsc_queue.sv
module pdsc_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  pdsc_pkg::pdsc_push_type push,
   input  logic                    pop,
   output logic                    out_valid,
   output pdsc_pkg::pdsc_item_type out_item,
   output logic [$clog2(pdsc_pkg::QUEUE_DEPTH+1)-1:0] count
);

   localparam int DEPTH = pdsc_pkg::QUEUE_DEPTH;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);

   pdsc_pkg::pdsc_item_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ff,    wr_in;
   logic [AW-1:0] rd_ff,    rd_in;
   logic [CW-1:0] count_ff, count_in;
   logic [1:0]    n_push;

   always_comb begin
      n_push   = 2'(push.valid_a) + 2'(push.valid_b);
      wr_in    = wr_ff + AW'(n_push);
      rd_in    = rd_ff + AW'(pop);
      count_in = count_ff + CW'(n_push) - CW'(pop);
   end

   // Advance pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   // Write up to two beats in order
   always_ff @(posedge clock) begin
      if (push.valid_a) mem_ff[wr_ff] <= push.item_a;
      if (push.valid_b) mem_ff[wr_ff + AW'(1)] <= push.item_b;
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign count     = count_ff;

endmodule

// File: hw/rtl/pd_source_caps_parser_top.sv
// Source-capabilities parser: takes one message byte per cycle on req_ and
// returns a decoded beat on rsp_ for every supply object completed, plus a
// summary beat when the byte flagged final_byte arrives (after the object
// beat if that byte also closes an object). A byte is taken every cycle while
// the consumer keeps up. A result beat passes through the parse register and
// the summary register, is then written into the 8-entry result queue and is
// presented on rsp_ from there.
// req_stall rises whenever the queue and the two processing stages together
// could not absorb two more result beats, so a stalled rsp_ side throttles
// the input. Write the csr_ registers only while no byte is in flight.
module pd_source_caps_parser_top #(
   parameter int MESSAGE_BYTES = pdsc_pkg::MESSAGE_BYTES_DEF,
   parameter int MAX_OBJECTS   = pdsc_pkg::MAX_OBJECTS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_first_byte,
   input  logic        req_final_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_entry_index,
   output logic [2:0]  rsp_supply_kind,
   output logic [15:0] rsp_min_mv,
   output logic [15:0] rsp_max_mv,
   output logic [12:0] rsp_limit_value,
   output logic [5:0]  rsp_voltage_mask,
   output logic [14:0] rsp_pps_min_mv,
   output logic [14:0] rsp_pps_max_mv,
   output logic [7:0]  rsp_pps_setpoint,
   output logic        rsp_is_summary,

   input  logic                               csr_write,
   input  logic [pdsc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pdsc_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int CW = $clog2(pdsc_pkg::QUEUE_DEPTH + 1);

   logic [7:0]  setpoint_ff, setpoint_in;
   logic [14:0] floor_ff,    floor_in;

   logic                    req_accept;
   logic                    rsp_accept;
   pdsc_pkg::pdsc_rec_type  rec;
   pdsc_pkg::pdsc_push_type push;
   pdsc_pkg::pdsc_item_type out_item;
   logic [1:0]              s2_load;
   logic [CW-1:0]           q_count;
   logic [CW+1:0]           committed;

   // Configuration writes
   always_comb begin
      setpoint_in = setpoint_ff;
      floor_in    = floor_ff;
      if (csr_write) begin
         case (csr_index)
            pdsc_pkg::CSR_SETPOINT: setpoint_in = csr_data[7:0];
            pdsc_pkg::CSR_FLOOR:    floor_in    = csr_data[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff <= pdsc_pkg::SETPOINT_RESET;
         floor_ff    <= pdsc_pkg::FLOOR_RESET;
      end else begin
         setpoint_ff <= setpoint_in;
         floor_ff    <= floor_in;
      end
   end

   // Stall input unless two more beats are sure to fit
   always_comb begin
      committed = (CW+2)'(q_count) + (CW+2)'(rec.obj_valid) + (CW+2)'(rec.sum_valid)
                + (CW+2)'(s2_load);
      req_stall = !(committed <= (CW+2)'(pdsc_pkg::QUEUE_DEPTH - 2));
   end

   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid && !rsp_stall;

   pdsc_parser #(
      .MESSAGE_BYTES (MESSAGE_BYTES),
      .MAX_OBJECTS   (MAX_OBJECTS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .data_byte  (req_data_byte),
      .first_byte (req_first_byte),
      .final_byte (req_final_byte),
      .rec        (rec)
   );

   pdsc_summary u_summary (
      .clock    (clock),
      .reset    (reset),
      .rec      (rec),
      .setpoint (setpoint_ff),
      .floor_mv (floor_ff),
      .push     (push),
      .load     (s2_load)
   );

   pdsc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_accept),
      .out_valid (rsp_valid),
      .out_item  (out_item),
      .count     (q_count)
   );

   assign rsp_entry_index  = out_item.entry_index;
   assign rsp_supply_kind  = out_item.supply_kind;
   assign rsp_min_mv       = out_item.min_mv;
   assign rsp_max_mv       = out_item.max_mv;
   assign rsp_limit_value  = out_item.limit_value;
   assign rsp_voltage_mask = out_item.voltage_mask;
   assign rsp_pps_min_mv   = out_item.pps_min_mv;
   assign rsp_pps_max_mv   = out_item.pps_max_mv;
   assign rsp_pps_setpoint = out_item.pps_setpoint;
   assign rsp_is_summary   = out_item.is_summary;

   // Queue never overflows
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_count <= CW'(pdsc_pkg::QUEUE_DEPTH))
      else $error("result queue overflow");

   // A final byte always yields a summary record next cycle
   a_final_summary: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_final_byte |=> rec.sum_valid)
      else $error("final byte lost its summary");

   // The clamped setpoint never exceeds the programmable maximum
   a_setpoint_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_summary |->
         (17'(rsp_pps_setpoint) * 17'd100) <= 17'(rsp_pps_max_mv))
      else $error("setpoint above programmable maximum");

endmodule
